// ----- design/mls_pkg.sv -----
// Shared types and constants for the Mobius linear sieve core.
// No dependencies; imported by mobius_linear_sieve_core.
package mls_pkg;

  // Fixed field widths of the stream payloads.
  localparam int NUM_W    = 17;
  localparam int MU_W     = 2;
  localparam int MERT_W   = 18;
  localparam int LIMIT_W  = 17;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 56;

  // Bit positions inside out_tdata.
  localparam int OD_NUM_LO  = 0;
  localparam int OD_MU_LO   = OD_NUM_LO + NUM_W;
  localparam int OD_SPF_LO  = OD_MU_LO + MU_W;
  localparam int OD_MERT_LO = OD_SPF_LO + NUM_W;
  localparam int OD_PAD_LO  = OD_MERT_LO + MERT_W;

  // Mobius value codes, two's complement on two bits.
  localparam logic signed [MU_W-1:0] MU_POS  = 2'sb01;
  localparam logic signed [MU_W-1:0] MU_ZERO = 2'sb00;
  localparam logic signed [MU_W-1:0] MU_NEG  = 2'sb11;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_MRD,
    ST_MMUL,
    ST_MWR,
    ST_EMIT
  } state_t;

endpackage

// ----- design/mobius_linear_sieve_core.sv -----
// Top level of the Mobius linear sieve: sequencer, factor, Mobius and prime memories.
// Depends on mls_pkg for field widths, Mobius codes and the state type.
//
// Usage. Each input beat on the in_ channel is one tick. in_tdata[0] is the restart
// flag: a restart beat clears the run and gives no result; any other beat moves the
// sieve on to the next number and, while that number stays within the limit, gives
// exactly one result beat on the out_ channel. The result beat carries the number,
// its Mobius value, its smallest prime factor and the running Mertens sum in
// out_tdata; out_tuser flags a prime and out_tlast marks the number equal to the
// limit. Ticks past the limit are taken and dropped until a restart or higher limit.
// The user writes the limit through cfg_we/cfg_wdata while idle; no check enforces it.
//
// Sequence. An advancing beat goes through ST_LOOK, then ST_MRD, ST_MMUL and ST_MWR
// for each prime tried, one prime at a time, and ends in ST_EMIT; the walk stops when
// it runs off the end of the prime list, marks p equal to the smallest factor, or
// meets a larger prime or a multiple above MAX_N. in_tready is low from acceptance
// until the block is back in ST_IDLE, so a new beat is taken only after the last has
// left ST_EMIT. Ticks past the limit are taken in ST_IDLE and leave it there.
//
// Reset and restart. After reset, and after every restart beat, the factor memory
// is swept to zero, one entry a cycle, across all MAX_N+1 entries; in_tready stays low
// during the sweep, while configuration writes are still taken.
// Stalls. The result sits in an output register; the next beat may be accepted
// while it waits, and that beat's own result is held back until the register frees.
module mobius_linear_sieve_core #(
  parameter int MAX_N      = 65536,
  parameter int MAX_PRIMES = 8192
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata fields, lowest bit up: restart (1), zero padding (7).
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mls_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata fields, lowest bit up: number (17), mobius (2), smallest_factor (17),
  // mertens (18), zero padding (2).
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mls_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser fields, lowest bit up: is_prime (1).
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [mls_pkg::LIMIT_W-1:0]       cfg_wdata
);
  import mls_pkg::*;

  // Width of a number up to MAX_N, and of the comparison against the limit.
  localparam int NW  = $clog2(MAX_N + 1);
  localparam int CW  = (NW > LIMIT_W) ? NW : LIMIT_W;
  localparam int PCW = $clog2(MAX_PRIMES + 1);
  localparam int PAW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int QW  = 2 * NW;

  // Memories. The factor store is cleared by a sweep; the Mobius store and the
  // prime list are only ever read at entries already written in the current run.
  logic [NW-1:0]              factor_mem [0:MAX_N];
  logic signed [MU_W-1:0]     mobius_mem [0:MAX_N];
  logic [NW-1:0]              prime_mem  [0:MAX_PRIMES-1];

  state_t                     state_r, state_nxt;
  logic [LIMIT_W-1:0]         limit_r;
  logic [NW-1:0]              cur_r;
  logic [PCW-1:0]             cnt_r;
  logic [PCW-1:0]             j_r;
  logic [MERT_W-1:0]          sum_r;
  logic [NW-1:0]              clr_r;

  logic [NW-1:0]              frd_r;
  logic signed [MU_W-1:0]     mrd_r;
  logic [NW-1:0]              prd_r;

  logic [NW-1:0]              spf_r;
  logic signed [MU_W-1:0]     mu_r;
  logic                       prime_r;
  logic [NW-1:0]              p_r;
  logic [QW-1:0]              q_r;

  logic                       out_valid_r;
  logic [OUT_DATA_W-1:0]      out_data_r;
  logic                       out_user_r;
  logic                       out_last_r;

  logic [CW-1:0]              lim_ext;
  logic [CW-1:0]              eff;
  logic [NW-1:0]              next_num;
  logic                       accept;
  logic                       restart;
  logic                       advance;
  logic                       emit;
  logic                       mark_stop;

  logic                       f_we;
  logic [NW-1:0]              f_waddr;
  logic [NW-1:0]              f_wdata;
  logic                       m_we;
  logic signed [MU_W-1:0]     m_wdata;

  logic [NW-1:0]              look_spf;
  logic signed [MU_W-1:0]     look_mu;
  logic                       look_prime;
  logic [MERT_W-1:0]          sum_next;

  // Effective limit: zero acts as one, anything above MAX_N acts as MAX_N.
  always_comb begin
    lim_ext = CW'(limit_r);
    if (lim_ext == '0) begin
      eff = CW'(1);
    end else if (lim_ext > CW'(MAX_N)) begin
      eff = CW'(MAX_N);
    end else begin
      eff = lim_ext;
    end
  end

  assign next_num  = cur_r + NW'(1);
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign restart   = in_tdata[0];
  assign advance   = accept && !restart && (CW'(cur_r) < eff);
  assign emit      = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign mark_stop = (p_r > spf_r) || (q_r > QW'(MAX_N));

  // Classification of the current number from the two memory reads.
  always_comb begin
    look_prime = 1'b0;
    if (cur_r == NW'(1)) begin
      look_spf = '0;
      look_mu  = MU_POS;
    end else if (frd_r == '0) begin
      look_prime = 1'b1;
      look_spf   = cur_r;
      look_mu    = MU_NEG;
    end else begin
      look_spf = frd_r;
      look_mu  = mrd_r;
    end
  end

  assign sum_next = sum_r + {{(MERT_W-MU_W){mu_r[MU_W-1]}}, mu_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == NW'(MAX_N)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && restart) begin
          state_nxt = ST_CLEAR;
        end else if (advance) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: state_nxt = ST_MRD;
      ST_MRD: begin
        state_nxt = (j_r < cnt_r) ? ST_MMUL : ST_EMIT;
      end
      ST_MMUL: state_nxt = ST_MWR;
      ST_MWR: begin
        if (mark_stop || (p_r == spf_r)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MRD;
        end
      end
      ST_EMIT: begin
        if (emit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Write port of the factor and Mobius memories: sweep or mark.
  always_comb begin
    f_we    = 1'b0;
    f_waddr = q_r[NW-1:0];
    f_wdata = p_r;
    m_we    = 1'b0;
    m_wdata = (p_r == spf_r) ? MU_ZERO : -mu_r;
    if (state_r == ST_CLEAR) begin
      f_we    = 1'b1;
      f_waddr = clr_r;
      f_wdata = '0;
    end else if ((state_r == ST_MWR) && !mark_stop) begin
      f_we = 1'b1;
      m_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (f_we) factor_mem[f_waddr] <= f_wdata;
    frd_r <= factor_mem[next_num];
  end

  always_ff @(posedge clk) begin
    if (m_we) mobius_mem[q_r[NW-1:0]] <= m_wdata;
    mrd_r <= mobius_mem[next_num];
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_LOOK) && look_prime && (cnt_r < PCW'(MAX_PRIMES))) begin
      prime_mem[cnt_r[PAW-1:0]] <= cur_r;
    end
    prd_r <= prime_mem[j_r[PAW-1:0]];
  end

  // Control counters and the limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      cur_r       <= '0;
      cnt_r       <= '0;
      j_r         <= '0;
      sum_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (state_r == ST_CLEAR) clr_r <= clr_r + NW'(1);
      if (accept && restart) begin
        cur_r <= '0;
        cnt_r <= '0;
        sum_r <= '0;
        clr_r <= '0;
      end
      if (advance) cur_r <= next_num;
      if (state_r == ST_LOOK) begin
        j_r <= '0;
        if (look_prime && (cnt_r < PCW'(MAX_PRIMES))) cnt_r <= cnt_r + PCW'(1);
      end
      if ((state_r == ST_MWR) && !mark_stop) j_r <= j_r + PCW'(1);
      if (emit) begin
        sum_r       <= sum_next;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers of the item in flight and the output register.
  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK) begin
      spf_r   <= look_spf;
      mu_r    <= look_mu;
      prime_r <= look_prime;
    end
    if (state_r == ST_MMUL) begin
      p_r <= prd_r;
      q_r <= QW'(prd_r) * QW'(cur_r);
    end
    if (emit) begin
      out_data_r <= {{(OUT_DATA_W-OD_PAD_LO){1'b0}}, sum_next, NUM_W'(spf_r), mu_r,
                     NUM_W'(cur_r)};
      out_user_r <= prime_r;
      out_last_r <= (CW'(cur_r) == eff);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for mobius_linear_sieve_core: a directed table, then random phases.
// Depends on mls_pkg and the core; keeps its own sieve model to predict untyped result beats.
module testbench;
  import mls_pkg::*;

  // Sizes match the core's defaults. At MAX_N of 65536 there are fewer primes than the
  // prime list can hold, so the list never fills and every prime gets its multiples marked.
  localparam int SIEVE_N       = 65536;
  localparam int SIEVE_PRIMES  = 8192;
  localparam int ITEM_TARGET   = 1600;
  localparam int MAX_RESTARTS  = 5;
  // A restart sweeps all MAX_N+1 entries of the factor memory with nothing accepted, so the
  // watchdog has to sit well above the length of that sweep.
  localparam int STALL_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // One result beat, split into its fields.
  typedef struct packed {
    logic [NUM_W-1:0]         number;
    logic signed [MU_W-1:0]   mobius;
    logic [NUM_W-1:0]         factor;
    logic                     prime;
    logic signed [MERT_W-1:0] mertens;
    logic                     at_limit;
  } sieve_beat_t;

  // One row of the directed table. Where typed is set, the row carries its own answer
  // (gives says whether a result beat is due at all); otherwise the sieve model decides.
  typedef struct {
    bit                 set_limit;
    logic [LIMIT_W-1:0] limit_val;
    bit                 restart;
    bit                 typed;
    bit                 gives;
    sieve_beat_t        beat;
  } dir_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wdata  = '0;

  // Sieve model state: smallest factor and Mobius value per number, the prime list,
  // the run counters and a shadow of the limit register.
  int unsigned            spf_mem   [0:SIEVE_N];
  logic signed [MU_W-1:0] mu_mem    [0:SIEVE_N];
  int unsigned            prime_mem [0:SIEVE_PRIMES-1];
  int unsigned            prime_total;
  int unsigned            cur_num;
  logic [MERT_W-1:0]      mertens_acc;
  logic [LIMIT_W-1:0]     limit_shadow;

  sieve_beat_t beats_due[$];
  dir_row_t    dir_tab[$];
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  int          errors         = 0;
  int          idle_cycles    = 0;

  always #4 clk = ~clk;

  mobius_linear_sieve_core #(
    .MAX_N      (SIEVE_N),
    .MAX_PRIMES (SIEVE_PRIMES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // One tick of the linear sieve. A restart clears the run and gives nothing; an
  // advancing tick below the effective limit reports the next number and marks p*i up to
  // MAX_N for every listed prime p up to spf(i), so that each composite is visited once.
  function automatic bit advance_sieve(input bit restart, output sieve_beat_t beat);
    int unsigned            eff;
    int unsigned            num;
    int unsigned            spf;
    int unsigned            p;
    int unsigned            j;
    longint unsigned        q;
    logic signed [MU_W-1:0] mu;
    bit                     prime;
    bit                     done;
    beat = '0;
    if (restart) begin
      foreach (spf_mem[k]) spf_mem[k] = 0;
      prime_total = 0;
      cur_num     = 0;
      mertens_acc = '0;
      return 1'b0;
    end
    // A limit of zero behaves as one; anything above MAX_N behaves as MAX_N.
    eff = 32'(limit_shadow);
    if (eff < 1) eff = 1;
    if (eff > SIEVE_N) eff = SIEVE_N;
    if (cur_num >= eff) return 1'b0;
    cur_num++;
    num   = cur_num;
    prime = 1'b0;
    if (num == 1) begin
      mu         = MU_POS;
      spf        = 0;
      mu_mem[1]  = MU_POS;
    end else if (spf_mem[num] == 0) begin
      prime        = 1'b1;
      spf          = num;
      spf_mem[num] = num;
      if (prime_total < SIEVE_PRIMES) begin
        prime_mem[prime_total] = num;
        prime_total++;
      end
      mu          = MU_NEG;
      mu_mem[num] = MU_NEG;
    end else begin
      spf = spf_mem[num];
      mu  = mu_mem[num];
    end
    done = 1'b0;
    for (j = 0; j < prime_total && !done; j++) begin
      p = prime_mem[j];
      q = longint'(p) * longint'(num);
      if (p > spf || q > SIEVE_N) begin
        done = 1'b1;
      end else begin
        spf_mem[q] = p;
        if (p == spf) begin
          // p divides i already, so p*p divides p*i.
          mu_mem[q] = MU_ZERO;
          done      = 1'b1;
        end else begin
          mu_mem[q] = -mu;
        end
      end
    end
    mertens_acc     = mertens_acc + {{(MERT_W-MU_W){mu[MU_W-1]}}, mu};
    beat.number     = num[NUM_W-1:0];
    beat.mobius     = mu;
    beat.factor     = spf[NUM_W-1:0];
    beat.prime      = prime;
    beat.mertens    = mertens_acc;
    beat.at_limit   = (num == eff);
    return 1'b1;
  endfunction

  function automatic dir_row_t mk_row(bit set_limit, int unsigned limit_val, bit restart,
                                      bit typed, bit gives, int num, int mu, int spf,
                                      bit prime, int mertens, bit at_limit);
    dir_row_t r;
    r.set_limit     = set_limit;
    r.limit_val     = LIMIT_W'(limit_val);
    r.restart       = restart;
    r.typed         = typed;
    r.gives         = gives;
    r.beat.number   = NUM_W'(num);
    r.beat.mobius   = MU_W'(mu);
    r.beat.factor   = NUM_W'(spf);
    r.beat.prime    = prime;
    r.beat.mertens  = MERT_W'(mertens);
    r.beat.at_limit = at_limit;
    return r;
  endfunction

  function automatic void set_idle(idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin
        send_gap_pct   = 79;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_gap_pct   = 0;
        recv_stall_pct = 79;
      end
      IDLE_BOTH: begin
        send_gap_pct   = 13;
        recv_stall_pct = 13;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  // add_row appends a row to the directed table; queue_beat appends an expected beat.
  function automatic void add_row(input dir_row_t r);
    dir_tab = {dir_tab, r};
  endfunction

  function automatic void queue_beat(input sieve_beat_t b);
    beats_due = {beats_due, b};
  endfunction

  // Drives one tick and waits for its handshake. tvalid is only ever lowered at a
  // falling edge that comes before the one where it is raised again, so a back-to-back
  // beat keeps it high throughout.
  task automatic send_tick(input bit restart, output bit gives, output sieve_beat_t beat);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-1){1'b0}}, restart};
    do @(posedge clk); while (!in_tready);
    gives = advance_sieve(restart, beat);
  endtask

  // Stops sending and waits until every expected beat is out, then waits out SETTLE_CYCLES
  // so that ticks past the limit, which give no beat, have been taken as well.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_shadow = value;
  endtask

  // The receiver stalls at random according to the current idling phase.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result checker and watchdog. Every accepted result beat is compared field by field
  // with the oldest expected beat; the watchdog counts cycles in which neither channel
  // moves a beat.
  always @(posedge clk) begin : result_check
    sieve_beat_t got;
    sieve_beat_t want;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      got.number   = out_tdata[OD_NUM_LO +: NUM_W];
      got.mobius   = out_tdata[OD_MU_LO +: MU_W];
      got.factor   = out_tdata[OD_SPF_LO +: NUM_W];
      got.mertens  = out_tdata[OD_MERT_LO +: MERT_W];
      got.prime    = out_tuser;
      got.at_limit = out_tlast;
      if (beats_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected result beat: number %0d", $realtime, got.number);
      end else begin
        want = beats_due.pop_front();
        if (got.number !== want.number || got.mobius !== want.mobius ||
            got.factor !== want.factor || got.prime !== want.prime ||
            got.mertens !== want.mertens || got.at_limit !== want.at_limit) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"[%0t] result mismatch: expected n=%0d mu=%0d spf=%0d prime=%0b ",
                      "mertens=%0d last=%0b, got n=%0d mu=%0d spf=%0d prime=%0b ",
                      "mertens=%0d last=%0b"}, $realtime,
                     want.number, $signed(want.mobius), want.factor, want.prime,
                     $signed(want.mertens), want.at_limit,
                     got.number, $signed(got.mobius), got.factor, got.prime,
                     $signed(got.mertens), got.at_limit);
        end
      end
    end
  end

  initial begin
    sieve_beat_t        beat;
    bit                 gives;
    bit                 is_restart;
    int                 counted;
    int                 restarts_left;
    int                 phase;
    int                 n_beats;
    int                 restart_at;
    logic [LIMIT_W-1:0] new_limit;

    limit_shadow = LIMIT_RESET;
    void'(advance_sieve(1'b1, beat));
    set_idle(IDLE_NONE);

    // Directed table: the first numbers under the reset limit, then the limit extremes
    // (zero acting as one, all ones acting as MAX_N), a tick past the limit, a restart,
    // lowering the limit below the current number and raising it again mid-run.
    //             cfg  limit   rst typed gives  n  mu spf pr  mert last
    add_row(mk_row(0, 0,      0, 1, 1, 1,  1, 0, 0,  1, 0));
    add_row(mk_row(0, 0,      0, 1, 1, 2, -1, 2, 1,  0, 0));
    add_row(mk_row(0, 0,      0, 1, 1, 3, -1, 3, 1, -1, 0));
    add_row(mk_row(0, 0,      0, 1, 1, 4,  0, 2, 0, -1, 0));
    add_row(mk_row(0, 0,      0, 1, 1, 5, -1, 5, 1, -2, 0));
    add_row(mk_row(0, 0,      0, 1, 1, 6,  1, 2, 0, -1, 0));
    add_row(mk_row(1, 7,      0, 1, 1, 7, -1, 7, 1, -2, 1));
    add_row(mk_row(0, 0,      0, 1, 0, 0,  0, 0, 0,  0, 0));
    add_row(mk_row(1, 0,      0, 1, 0, 0,  0, 0, 0,  0, 0));
    add_row(mk_row(0, 0,      1, 1, 0, 0,  0, 0, 0,  0, 0));
    add_row(mk_row(0, 0,      0, 1, 1, 1,  1, 0, 0,  1, 1));
    add_row(mk_row(0, 0,      0, 1, 0, 0,  0, 0, 0,  0, 0));
    add_row(mk_row(1, 131071, 0, 1, 1, 2, -1, 2, 1,  0, 0));
    add_row(mk_row(1, 3,      0, 1, 1, 3, -1, 3, 1, -1, 1));
    add_row(mk_row(1, 1,      0, 1, 0, 0,  0, 0, 0,  0, 0));
    add_row(mk_row(1, 65536,  0, 1, 1, 4,  0, 2, 0, -1, 0));
    repeat (8) add_row(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // Reset is held low at the start; the core then sweeps its factor memory before it
    // takes the first beat.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].set_limit) begin
        settle();
        write_limit(dir_tab[r].limit_val);
      end
      send_tick(dir_tab[r].restart, gives, beat);
      if (dir_tab[r].typed) begin
        if (dir_tab[r].gives) queue_beat(dir_tab[r].beat);
      end else if (gives) begin
        queue_beat(beat);
      end
    end

    // Random phases. Each one starts from an idle core (the sender waits for every
    // expected beat), picks a new limit and an idling style, then sends a run of
    // non-restart ticks, now and then with one restart somewhere in the middle. Restarts
    // are kept few because each costs a full sweep of the factor memory.
    counted       = 0;
    restarts_left = MAX_RESTARTS;
    phase         = 0;
    while (counted < ITEM_TARGET) begin
      settle();
      set_idle(idle_mode_t'(phase % 4));
      case ($urandom_range(0, 7))
        0: new_limit = LIMIT_W'(cur_num + $urandom_range(1, 8));
        1: new_limit = LIMIT_W'($urandom_range(0, cur_num));
        2: new_limit = '1;
        3: new_limit = LIMIT_RESET;
        default: new_limit = LIMIT_W'(cur_num + $urandom_range(30, 200));
      endcase
      write_limit(new_limit);
      n_beats    = $urandom_range(20, 100);
      restart_at = -1;
      if (restarts_left > 0 && $urandom_range(0, 4) == 0)
        restart_at = $urandom_range(0, n_beats - 1);
      for (int b = 0; b < n_beats; b++) begin
        is_restart = (b == restart_at);
        send_tick(is_restart, gives, beat);
        if (gives) queue_beat(beat);
        counted++;
        if (is_restart) restarts_left--;
      end
      phase++;
    end

    settle();
    repeat (64) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
